>>> design/priority_goal_table_unit_assert.svh
// ----------------------------------------------------------------------------
// priority goal table assertion macros
// shared property forms for the goal table checkers
// ----------------------------------------------------------------------------
`ifndef PRIORITY_GOAL_TABLE_UNIT_ASSERT_SVH
`define PRIORITY_GOAL_TABLE_UNIT_ASSERT_SVH

// condition holds at every sampled edge out of reset
`define PGT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("goal table check failed");

// consequent holds in the same cycle as the antecedent
`define PGT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("goal table check failed");

// consequent holds in the cycle after the antecedent
`define PGT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("goal table check failed");

`endif

>>> design/pgt_pkg.sv
// ----------------------------------------------------------------------------
// pgt_pkg
// shared types, codes and widths of the priority goal table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgt_pkg;

    // table geometry
    localparam int GOAL_MAX = 16;
    localparam int IDX_W    = $clog2(GOAL_MAX);
    localparam int CNT_W    = $clog2(GOAL_MAX + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int PRI_W    = 16;
    localparam int TAG_W    = 16;
    localparam int POS_W    = 4;
    localparam int HELD_W   = 5;
    localparam int STATUS_W = 2;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // output data field offsets
    localparam int OUT_PRI_LO  = 0;
    localparam int OUT_TAG_LO  = 16;
    localparam int OUT_DONE_LO = 32;
    localparam int OUT_POS_LO  = 33;
    localparam int OUT_HELD_LO = 38 - 1;

    // selection floor, -1.0 in Q8.8
    localparam logic signed [PRI_W-1:0] PRI_FLOOR = -16'sd256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_NEXT,
        OP_COMPLETE,
        OP_CONSOLIDATE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_INDEX,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef struct packed {
        logic                    done;
        logic [TAG_W-1:0]        tag;
        logic signed [PRI_W-1:0] pri;
    } goal_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NX_RD,
        S_NX_CHK,
        S_CP_RD,
        S_CP_WR,
        S_SO_RDI,
        S_SO_LDI,
        S_SO_RDJ,
        S_SO_CHK,
        S_SO_SW1,
        S_SO_SW2,
        S_CM_RD,
        S_CM_CHK,
        S_FINISH
    } state_t;

endpackage

>>> design/pgt_ram.sv
// ----------------------------------------------------------------------------
// pgt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pgt_cmp.sv
// ----------------------------------------------------------------------------
// pgt_cmp
// shared priority compare used by the selection scan and the sort pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgt_cmp (
    input  pgt_pkg::goal_entry_t             cand,
    input  logic signed [pgt_pkg::PRI_W-1:0] ref_pri,
    output logic                             take
);

    // an open candidate wins only with a strictly greater priority
    always_comb
    begin
        take = !cand.done && (cand.pri > ref_pri);
    end

endmodule

>>> design/priority_goal_table_unit.sv
// ----------------------------------------------------------------------------
// priority_goal_table_unit
// goal table with add, select next, mark complete and consolidate
// ----------------------------------------------------------------------------
// Each transaction carries one operation and yields one result. The table sits
// in a 16-entry ram with one write and one registered read port, and every
// table access goes through that port under a small sequencer, with a read state
// before each state that uses the read data. The input is not ready while an
// operation runs; a finished result waits in the output register, and a new
// transaction is taken while it waits.
`timescale 1ns / 1ps

module priority_goal_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // request: tdata = new_priority, new_tag, slot_index (low bit up)
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pgt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // request: tuser = op
    input  logic [pgt_pkg::OP_W-1:0]          s_axis_tuser,
    // result: tdata = goal_priority, goal_tag, goal_done, goal_position,
    // entries_held (low bit up)
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pgt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // result: tuser = status
    output logic [pgt_pkg::STATUS_W-1:0]      m_axis_tuser
);

    localparam int IW = pgt_pkg::IDX_W;
    localparam int CW = pgt_pkg::CNT_W;

    // control registers
    pgt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // operation and sequencer registers
    logic [pgt_pkg::POS_W-1:0]         idx_in_reg, idx_in_next;
    logic [CW-1:0]                     i_reg, i_next;
    logic [CW-1:0]                     j_reg, j_next;
    logic [CW-1:0]                     w_reg, w_next;
    logic [IW-1:0]                     top_reg, top_next;
    pgt_pkg::goal_entry_t              top_data_reg, top_data_next;
    pgt_pkg::goal_entry_t              cur_reg, cur_next;
    logic                              found_reg, found_next;
    pgt_pkg::status_t                  status_reg, status_next;

    // result registers
    pgt_pkg::status_t                  out_status_reg, out_status_next;
    logic signed [pgt_pkg::PRI_W-1:0]  out_pri_reg, out_pri_next;
    logic [pgt_pkg::TAG_W-1:0]         out_tag_reg, out_tag_next;
    logic                              out_done_reg, out_done_next;
    logic [pgt_pkg::POS_W-1:0]         out_pos_reg, out_pos_next;
    logic [pgt_pkg::HELD_W-1:0]        out_held_reg, out_held_next;

    // ram port
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [IW-1:0]        ram_raddr;
    pgt_pkg::goal_entry_t ram_wdata;
    pgt_pkg::goal_entry_t ram_rdata;
    logic [$bits(pgt_pkg::goal_entry_t)-1:0] ram_rdata_raw;

    logic take;
    logic in_fire;

    pgt_ram #(
        .WIDTH ($bits(pgt_pkg::goal_entry_t)),
        .DEPTH (pgt_pkg::GOAL_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = pgt_pkg::goal_entry_t'(ram_rdata_raw);

    // one compare unit serves both scans
    pgt_cmp u_cmp (
        .cand    (ram_rdata),
        .ref_pri (top_data_reg.pri),
        .take    (take)
    );

    // stream ports
    assign s_axis_tready = (state_reg == pgt_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'b000000, out_held_reg, out_pos_reg, out_done_reg,
                            out_tag_reg, out_pri_reg};

    // sequencer next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        idx_in_next     = idx_in_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        w_next          = w_reg;
        top_next        = top_reg;
        top_data_next   = top_data_reg;
        cur_next        = cur_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_pri_next    = out_pri_reg;
        out_tag_next    = out_tag_reg;
        out_done_next   = out_done_reg;
        out_pos_next    = out_pos_reg;
        out_held_next   = out_held_reg;
        ram_we          = 1'b0;
        ram_waddr       = i_reg[IW-1:0];
        ram_wdata       = top_data_reg;
        ram_raddr       = j_reg[IW-1:0];

        // result leaves on its transaction
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pgt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_in_next = s_axis_tdata[35:32];
                    found_next  = 1'b0;
                    status_next = pgt_pkg::ST_OK;
                    i_next      = '0;
                    j_next      = '0;
                    w_next      = '0;
                    case (pgt_pkg::op_t'(s_axis_tuser))
                        pgt_pkg::OP_ADD:
                        begin
                            if (count_reg >= CW'(pgt_pkg::GOAL_MAX))
                            begin
                                status_next = pgt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = count_reg[IW-1:0];
                                ram_wdata.done = 1'b0;
                                ram_wdata.tag  = s_axis_tdata[31:16];
                                ram_wdata.pri  = s_axis_tdata[15:0];
                                count_next     = count_reg + CW'(1);
                            end
                            state_next = pgt_pkg::S_FINISH;
                        end
                        pgt_pkg::OP_NEXT:
                        begin
                            top_data_next.pri = pgt_pkg::PRI_FLOOR;
                            if (count_reg == '0)
                            begin
                                status_next = pgt_pkg::ST_NOT_FOUND;
                                state_next  = pgt_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = pgt_pkg::S_NX_RD;
                            end
                        end
                        pgt_pkg::OP_COMPLETE:
                        begin
                            if (CW'(s_axis_tdata[35:32]) >= count_reg)
                            begin
                                status_next = pgt_pkg::ST_BAD_INDEX;
                                state_next  = pgt_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = pgt_pkg::S_CP_RD;
                            end
                        end
                        pgt_pkg::OP_CONSOLIDATE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                state_next = pgt_pkg::S_SO_RDI;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                state_next = pgt_pkg::S_CM_RD;
                            end
                            else
                            begin
                                state_next = pgt_pkg::S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = pgt_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            // selection scan over held entries
            pgt_pkg::S_NX_RD:
            begin
                ram_raddr  = j_reg[IW-1:0];
                state_next = pgt_pkg::S_NX_CHK;
            end
            pgt_pkg::S_NX_CHK:
            begin
                if (take)
                begin
                    top_data_next = ram_rdata;
                    top_next      = j_reg[IW-1:0];
                    found_next    = 1'b1;
                end
                j_next = j_reg + CW'(1);
                if (j_reg + CW'(1) == count_reg)
                begin
                    status_next = (found_reg || take) ? pgt_pkg::ST_OK
                                                      : pgt_pkg::ST_NOT_FOUND;
                    state_next  = pgt_pkg::S_FINISH;
                end
                else
                begin
                    state_next = pgt_pkg::S_NX_RD;
                end
            end

            // mark complete as read, modify, write
            pgt_pkg::S_CP_RD:
            begin
                ram_raddr  = idx_in_reg[IW-1:0];
                state_next = pgt_pkg::S_CP_WR;
            end
            pgt_pkg::S_CP_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = idx_in_reg[IW-1:0];
                ram_wdata      = ram_rdata;
                ram_wdata.done = 1'b1;
                state_next     = pgt_pkg::S_FINISH;
            end

            // sort pass: load the entry at position i
            pgt_pkg::S_SO_RDI:
            begin
                ram_raddr  = i_reg[IW-1:0];
                state_next = pgt_pkg::S_SO_LDI;
            end
            pgt_pkg::S_SO_LDI:
            begin
                cur_next      = ram_rdata;
                top_data_next = ram_rdata;
                top_next      = i_reg[IW-1:0];
                j_next        = i_reg + CW'(1);
                state_next    = pgt_pkg::S_SO_RDJ;
            end

            // sort pass: find the best open entry beyond i
            pgt_pkg::S_SO_RDJ:
            begin
                ram_raddr  = j_reg[IW-1:0];
                state_next = pgt_pkg::S_SO_CHK;
            end
            pgt_pkg::S_SO_CHK:
            begin
                if (take)
                begin
                    top_data_next = ram_rdata;
                    top_next      = j_reg[IW-1:0];
                end
                j_next = j_reg + CW'(1);
                if (j_reg + CW'(1) == count_reg)
                begin
                    state_next = pgt_pkg::S_SO_SW1;
                end
                else
                begin
                    state_next = pgt_pkg::S_SO_RDJ;
                end
            end

            // sort pass: swap in the SW1 and SW2 write states, skipped when i is already best
            pgt_pkg::S_SO_SW1:
            begin
                if (top_reg != i_reg[IW-1:0])
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = i_reg[IW-1:0];
                    ram_wdata  = top_data_reg;
                    state_next = pgt_pkg::S_SO_SW2;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(2) < count_reg)
                    begin
                        state_next = pgt_pkg::S_SO_RDI;
                    end
                    else
                    begin
                        i_next     = '0;
                        w_next     = '0;
                        state_next = pgt_pkg::S_CM_RD;
                    end
                end
            end
            pgt_pkg::S_SO_SW2:
            begin
                ram_we    = 1'b1;
                ram_waddr = top_reg;
                ram_wdata = cur_reg;
                i_next    = i_reg + CW'(1);
                if (i_reg + CW'(2) < count_reg)
                begin
                    state_next = pgt_pkg::S_SO_RDI;
                end
                else
                begin
                    i_next     = '0;
                    w_next     = '0;
                    state_next = pgt_pkg::S_CM_RD;
                end
            end

            // compaction: keep open entries in order
            pgt_pkg::S_CM_RD:
            begin
                ram_raddr  = i_reg[IW-1:0];
                state_next = pgt_pkg::S_CM_CHK;
            end
            pgt_pkg::S_CM_CHK:
            begin
                if (!ram_rdata.done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[IW-1:0];
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + CW'(1);
                end
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == count_reg)
                begin
                    count_next = ram_rdata.done ? w_reg : (w_reg + CW'(1));
                    state_next = pgt_pkg::S_FINISH;
                end
                else
                begin
                    state_next = pgt_pkg::S_CM_RD;
                end
            end

            // load the result once the output register is free
            pgt_pkg::S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_held_next   = pgt_pkg::HELD_W'(count_reg);
                    if (found_reg)
                    begin
                        out_pri_next  = top_data_reg.pri;
                        out_tag_next  = top_data_reg.tag;
                        out_done_next = top_data_reg.done;
                        out_pos_next  = pgt_pkg::POS_W'(top_reg);
                    end
                    else
                    begin
                        out_pri_next  = '0;
                        out_tag_next  = '0;
                        out_done_next = 1'b0;
                        out_pos_next  = '0;
                    end
                    state_next = pgt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pgt_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and sequencer registers
    always_ff @(posedge clk)
    begin
        idx_in_reg     <= idx_in_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        w_reg          <= w_next;
        top_reg        <= top_next;
        top_data_reg   <= top_data_next;
        cur_reg        <= cur_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_pri_reg    <= out_pri_next;
        out_tag_reg    <= out_tag_next;
        out_done_reg   <= out_done_next;
        out_pos_reg    <= out_pos_next;
        out_held_reg   <= out_held_next;
    end

endmodule

>>> design/pgt_checker.sv
// ----------------------------------------------------------------------------
// pgt_checker
// port level checks of the goal table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_goal_table_unit_assert.svh"

module pgt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [pgt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input logic [pgt_pkg::OP_W-1:0]          s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pgt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [pgt_pkg::STATUS_W-1:0]      m_axis_tuser
);

    logic                        in_fire;
    logic                        res_bad;
    logic [pgt_pkg::HELD_W-1:0]  res_held;
    logic                        res_done;
    logic [pgt_pkg::OUT_HELD_LO-1:0] res_sel;

    // result fields
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign res_bad  = (m_axis_tuser != pgt_pkg::ST_OK);
    assign res_held = m_axis_tdata[pgt_pkg::OUT_HELD_LO +: pgt_pkg::HELD_W];
    assign res_done = m_axis_tdata[pgt_pkg::OUT_DONE_LO];
    assign res_sel  = m_axis_tdata[pgt_pkg::OUT_HELD_LO-1:0];

    // a stalled result holds
    `PGT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an accepted transaction keeps the unit busy for the next cycle
    `PGT_ASSERT_NEXT(a_busy, in_fire, !s_axis_tready)

    // entry count never passes the table size
    `PGT_ASSERT_IMPL(a_held, m_axis_tvalid, res_held <= pgt_pkg::HELD_W'(pgt_pkg::GOAL_MAX))

    // failed operations carry no selection
    `PGT_ASSERT_IMPL(a_nosel, m_axis_tvalid && res_bad, res_sel == '0)

    // a selected goal is never a completed one
    `PGT_ASSERT_ALWAYS(a_open, !m_axis_tvalid || !res_done)

endmodule

bind priority_goal_table_unit pgt_checker u_pgt_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for priority_goal_table_unit: a mirror of the goal
// table predicts the result of every request, and each result transaction is
// compared field by field against the oldest prediction
// ----------------------------------------------------------------------------

module tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PHASE_ITEMS  = 357;
    localparam int REPORT_CAP   = 50;

    // predicted content of one result transaction
    typedef struct {
        pgt_pkg::status_t                 status;
        logic signed [pgt_pkg::PRI_W-1:0] pri;
        logic [pgt_pkg::TAG_W-1:0]        tag;
        logic                             done;
        logic [pgt_pkg::POS_W-1:0]        pos;
        logic [pgt_pkg::HELD_W-1:0]       held;
    } goal_result_t;

    // mirror of the goal table and the queue of predicted results
    class goal_table_tracker;
        pgt_pkg::goal_entry_t goal_mem [pgt_pkg::GOAL_MAX];
        int                   held_n;
        goal_result_t         pending_results [$];
        int                   fail_count;

        function new();
            held_n     = 0;
            fail_count = 0;
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(pgt_pkg::op_t op,
                                   logic signed [pgt_pkg::PRI_W-1:0] pri,
                                   logic [pgt_pkg::TAG_W-1:0] tag,
                                   logic [pgt_pkg::POS_W-1:0] idx);
            goal_result_t                     res;
            int                               best;
            int                               top;
            int                               w;
            logic signed [pgt_pkg::PRI_W-1:0] lead_pri;
            pgt_pkg::goal_entry_t             swap_tmp;

            res.status = pgt_pkg::ST_OK;
            res.pri    = '0;
            res.tag    = '0;
            res.done   = 1'b0;
            res.pos    = '0;
            case (op)
                pgt_pkg::OP_ADD:
                begin
                    if (held_n >= pgt_pkg::GOAL_MAX)
                    begin
                        res.status = pgt_pkg::ST_FULL;
                    end
                    else
                    begin
                        goal_mem[held_n].pri  = pri;
                        goal_mem[held_n].tag  = tag;
                        goal_mem[held_n].done = 1'b0;
                        held_n++;
                    end
                end
                pgt_pkg::OP_NEXT:
                begin
                    // first uncompleted entry with the greatest priority above the floor
                    best     = -1;
                    lead_pri = pgt_pkg::PRI_FLOOR;
                    for (int i = 0; i < held_n; i++)
                    begin
                        if (!goal_mem[i].done && goal_mem[i].pri > lead_pri)
                        begin
                            lead_pri = goal_mem[i].pri;
                            best     = i;
                        end
                    end
                    if (best < 0)
                    begin
                        res.status = pgt_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        res.pri  = goal_mem[best].pri;
                        res.tag  = goal_mem[best].tag;
                        res.done = goal_mem[best].done;
                        res.pos  = best[pgt_pkg::POS_W-1:0];
                    end
                end
                pgt_pkg::OP_COMPLETE:
                begin
                    if (int'(idx) >= held_n)
                        res.status = pgt_pkg::ST_BAD_INDEX;
                    else
                        goal_mem[idx].done = 1'b1;
                end
                default:
                begin
                    // one selection pass, only uncompleted candidates move forward
                    for (int i = 0; i + 1 < held_n; i++)
                    begin
                        top = i;
                        for (int j = i + 1; j < held_n; j++)
                        begin
                            if (!goal_mem[j].done && goal_mem[j].pri > goal_mem[top].pri)
                                top = j;
                        end
                        if (top != i)
                        begin
                            swap_tmp      = goal_mem[i];
                            goal_mem[i]   = goal_mem[top];
                            goal_mem[top] = swap_tmp;
                        end
                    end
                    // squeeze out completed entries, order kept
                    w = 0;
                    for (int i = 0; i < held_n; i++)
                    begin
                        if (!goal_mem[i].done)
                        begin
                            goal_mem[w] = goal_mem[i];
                            w++;
                        end
                    end
                    held_n = w;
                end
            endcase
            res.held = held_n[pgt_pkg::HELD_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, int expv, int actv);
            if (expv != actv)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            end
        endfunction

        // check one result transaction against the oldest prediction
        function void check_result(logic [pgt_pkg::OUT_DATA_W-1:0] data,
                                   logic [pgt_pkg::STATUS_W-1:0] user);
            goal_result_t exp_res;

            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("result transaction with no pending prediction");
                return;
            end
            exp_res = pending_results.pop_front();
            compare_field("status", int'(exp_res.status), int'(user));
            compare_field("goal_priority", int'(exp_res.pri), int'($signed(data[15:0])));
            compare_field("goal_tag", int'(exp_res.tag), int'(data[31:16]));
            compare_field("goal_done", int'(exp_res.done), int'(data[32]));
            compare_field("goal_position", int'(exp_res.pos), int'(data[36:33]));
            compare_field("entries_held", int'(exp_res.held), int'(data[41:37]));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [pgt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [pgt_pkg::OP_W-1:0]       s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pgt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [pgt_pkg::STATUS_W-1:0]   m_axis_tuser;

    goal_table_tracker sb = new();
    int                send_idle = 0;
    int                recv_idle = 0;
    int                quiet_cycles = 0;

    priority_goal_table_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_idle);
    end

    // result transaction check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // present one request transaction and hold it until accepted
    task automatic send_item(input pgt_pkg::op_t op,
                             input logic [pgt_pkg::PRI_W-1:0] pri,
                             input logic [pgt_pkg::TAG_W-1:0] tag,
                             input logic [pgt_pkg::POS_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0000, idx, tag, pri};
        s_axis_tuser  = op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, pri, tag, idx);
    endtask

    // random request, weighted toward valid indices and interesting priorities
    task automatic send_random();
        pgt_pkg::op_t              op;
        logic [pgt_pkg::PRI_W-1:0] pri;
        logic [pgt_pkg::TAG_W-1:0] tag;
        logic [pgt_pkg::POS_W-1:0] idx;
        int                        r;
        int                        add_weight;

        tag = 16'($urandom);
        idx = 4'($urandom_range(15));
        case ($urandom_range(7))
            0: pri = 16'hff00;
            1: pri = 16'hff01;
            2: pri = 16'hfeff;
            3: pri = ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
            4: pri = 16'($urandom_range(3) * 128);
            default: pri = 16'($urandom);
        endcase
        add_weight = (sb.held_n < 8) ? 45 : 30;
        r = int'($urandom_range(99));
        if (r < add_weight)
        begin
            op = pgt_pkg::OP_ADD;
        end
        else if (r < add_weight + 25)
        begin
            op = pgt_pkg::OP_NEXT;
        end
        else if (r < 90)
        begin
            op = pgt_pkg::OP_COMPLETE;
            if (sb.held_n > 0 && $urandom_range(9) < 8)
                idx = 4'($urandom_range(sb.held_n - 1));
        end
        else
        begin
            op = pgt_pkg::OP_CONSOLIDATE;
        end
        send_item(op, pri, tag, idx);
    endtask

    // drop valid and hold off until every predicted result has arrived
    task automatic wait_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pgt_pkg::OP_ADD;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_idle = 33;
        recv_idle = 54;

        // empty table: nothing to pick, bad index, consolidate of nothing
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        send_item(pgt_pkg::OP_COMPLETE, 16'hffff, 16'hffff, 4'd15);
        send_item(pgt_pkg::OP_CONSOLIDATE, 16'h5555, 16'haaaa, 4'd5);
        // priority at the floor is never picked, just above it is
        send_item(pgt_pkg::OP_ADD, 16'hff00, 16'hffff, 4'd15);
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        send_item(pgt_pkg::OP_ADD, 16'hff01, 16'h0000, 4'd0);
        send_item(pgt_pkg::OP_NEXT, 16'hffff, 16'hffff, 4'd15);
        // extremes and a tie on the top priority
        send_item(pgt_pkg::OP_ADD, 16'h7fff, 16'h1234, 4'd3);
        send_item(pgt_pkg::OP_ADD, 16'h8000, 16'h8000, 4'd12);
        send_item(pgt_pkg::OP_ADD, 16'h7fff, 16'h4321, 4'd9);
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        // complete the winner twice, then the tie partner takes over
        send_item(pgt_pkg::OP_COMPLETE, 16'h0000, 16'h0000, 4'd2);
        send_item(pgt_pkg::OP_COMPLETE, 16'hffff, 16'hffff, 4'd2);
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        // index equal to the count is out of range
        send_item(pgt_pkg::OP_COMPLETE, 16'h0000, 16'h0000, 4'd5);
        send_item(pgt_pkg::OP_CONSOLIDATE, 16'h0000, 16'h0000, 4'd0);
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        // fill the table, then one add too many
        while (sb.held_n < pgt_pkg::GOAL_MAX)
            send_item(pgt_pkg::OP_ADD, 16'($urandom), 16'($urandom), 4'($urandom));
        send_item(pgt_pkg::OP_ADD, 16'h1111, 16'h2222, 4'd7);
        send_item(pgt_pkg::OP_COMPLETE, 16'h0000, 16'h0000, 4'd15);
        send_item(pgt_pkg::OP_CONSOLIDATE, 16'h0000, 16'h0000, 4'd0);
        send_item(pgt_pkg::OP_NEXT, 16'h0000, 16'h0000, 4'd0);
        wait_results();

        // random phases with changing back-pressure
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 33;
                    recv_idle = 54;
                end
                1:
                begin
                    send_idle = 54;
                    recv_idle = 33;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            wait_results();
        end

        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/pgt_pkg.sv
design/pgt_ram.sv
design/pgt_cmp.sv
design/priority_goal_table_unit.sv
design/pgt_checker.sv
test/tb.sv
